// ===== hdl/hbkd_pkg.sv =====
`default_nettype none
package hbkd_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int MAX_SLOTS = 6;
    localparam int MOD_BITS  = 8;
    localparam logic [7:0] MOD_BASE = 8'hE0;

    // Event positions in generation order: key presses, modifier presses,
    // modifier releases, key releases.
    localparam int EVT_CNT   = 2 * MAX_SLOTS + 2 * MOD_BITS;
    localparam int IDX_W     = $clog2(EVT_CNT);
    localparam int MODP_BASE = MAX_SLOTS;
    localparam int MODR_BASE = MAX_SLOTS + MOD_BITS;
    localparam int KEYR_BASE = MAX_SLOTS + 2 * MOD_BITS;

    typedef logic [7:0] key_t;
    typedef key_t [MAX_SLOTS-1:0] slots_t;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } in_t;

    typedef struct packed {
        logic [7:0] key_code;
        logic       pressed;
        logic       last_event;
    } out_t;

    typedef struct packed {
        logic                 press;
        logic [MAX_SLOTS-1:0] held;
    } lane_res_t;

    // Slots past KEY_SLOTS are not in use and read as empty.
    function automatic slots_t to_slots(in_t rpt);
        slots_t s;
        s[0] = rpt.key_slot_0;
        s[1] = rpt.key_slot_1;
        s[2] = rpt.key_slot_2;
        s[3] = rpt.key_slot_3;
        s[4] = rpt.key_slot_4;
        s[5] = rpt.key_slot_5;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            if (i >= KEY_SLOTS)
            begin
                s[i] = '0;
            end
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/hid_boot_report_key_differ_core.sv =====
`default_nettype none
// Boot keyboard report differ. A report word is taken only while the block is
// idle; once it is registered, the six slot lanes match it against the stored
// report and the resulting event mask is registered, and from then on one
// event word is emitted per cycle while out_ready allows, lowest event first.
// A report yields 0 to 20 events; the single-word output register lets the
// next report be accepted while the final event still waits. A report equal
// to the stored one, with no key code repeated, produces no words. last_event
// marks the final word of each report.
module hid_boot_report_key_differ_core (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  wire hbkd_pkg::in_t  in_data,
    output logic             out_valid,
    input  wire              out_ready,
    output hbkd_pkg::out_t   out_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                       state_reg, state_next;
    hbkd_pkg::in_t                    report_reg;
    logic [7:0]                       prior_mod_reg;
    hbkd_pkg::slots_t                 prior_keys_reg;
    hbkd_pkg::slots_t                 rel_keys_reg;
    logic [hbkd_pkg::EVT_CNT-1:0]     mask_reg, mask_next;
    logic                             out_valid_reg, out_valid_next;
    hbkd_pkg::out_t                   out_reg, out_next;

    hbkd_pkg::slots_t                                    new_slots;
    hbkd_pkg::lane_res_t [hbkd_pkg::MAX_SLOTS-1:0]       lanes;
    logic [hbkd_pkg::EVT_CNT-1:0]                        calc_mask;
    logic [hbkd_pkg::EVT_CNT-1:0]                        remain;
    logic [hbkd_pkg::IDX_W-1:0]                          idx;
    logic [7:0]                                          code;
    logic                                                load;

    assign new_slots = hbkd_pkg::to_slots(report_reg);

    for (genvar g = 0; g < hbkd_pkg::MAX_SLOTS; g++)
    begin : g_lane
        hbkd_lane u_lane (
            .key   (new_slots[g]),
            .prior (prior_keys_reg),
            .res   (lanes[g])
        );
    end

    hbkd_merge u_merge (
        .lanes     (lanes),
        .new_mod   (report_reg.modifier_bits),
        .prior_mod (prior_mod_reg),
        .prior     (prior_keys_reg),
        .mask      (calc_mask)
    );

    // Lowest pending event and its code.
    always_comb
    begin
        idx  = '0;
        code = '0;
        for (int p = hbkd_pkg::EVT_CNT - 1; p >= 0; p--)
        begin
            if (mask_reg[p])
            begin
                idx = p[hbkd_pkg::IDX_W-1:0];
            end
        end
        for (int i = 0; i < hbkd_pkg::MAX_SLOTS; i++)
        begin
            if (idx == hbkd_pkg::IDX_W'(i))
            begin
                code = new_slots[i];
            end
            if (idx == hbkd_pkg::IDX_W'(hbkd_pkg::KEYR_BASE + i))
            begin
                code = rel_keys_reg[i];
            end
        end
        for (int b = 0; b < hbkd_pkg::MOD_BITS; b++)
        begin
            if (idx == hbkd_pkg::IDX_W'(hbkd_pkg::MODP_BASE + b) ||
                idx == hbkd_pkg::IDX_W'(hbkd_pkg::MODR_BASE + b))
            begin
                code = hbkd_pkg::MOD_BASE + 8'(b);
            end
        end
    end

    assign remain   = mask_reg & (mask_reg - hbkd_pkg::EVT_CNT'(1));
    assign load     = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                mask_next  = calc_mask;
                state_next = (calc_mask != '0) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next      = 1'b1;
                    out_next.key_code   = code;
                    out_next.pressed    = (idx < hbkd_pkg::IDX_W'(hbkd_pkg::MODR_BASE));
                    out_next.last_event = (remain == '0);
                    mask_next           = remain;
                    if (remain == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            mask_reg       <= '0;
            prior_mod_reg  <= '0;
            prior_keys_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mask_reg      <= mask_next;
            if (state_reg == ST_CALC)
            begin
                prior_mod_reg  <= report_reg.modifier_bits;
                prior_keys_reg <= new_slots;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (in_valid && in_ready)
        begin
            report_reg <= in_data;
        end
        if (state_reg == ST_CALC)
        begin
            rel_keys_reg <= prior_keys_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The emit state is only entered with events pending.
    a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (mask_reg != '0))
        else $error("emit state with empty event mask");

    // A report never yields more than twenty events.
    a_event_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ($countones(mask_reg) <= 20))
        else $error("event count above limit");

    // Loading the final event of a report returns the block to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (load && remain == '0) |=> (state_reg == ST_IDLE && out_data.last_event))
        else $error("final event did not end the report");

    // Lane 0 claims at most one previous slot; the other lanes are not checked here.
    a_lane_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> $onehot0(lanes[0].held))
        else $error("lane matched more than one previous slot");

endmodule
`default_nettype wire

// ===== hdl/hbkd_lane.sv =====
`default_nettype none
// One new key slot matched against all previous slots.
module hbkd_lane (
    input  wire hbkd_pkg::key_t    key,
    input  wire hbkd_pkg::slots_t  prior,
    output hbkd_pkg::lane_res_t    res
);

    logic found;

    always_comb
    begin
        found     = 1'b0;
        res.held  = '0;
        for (int j = 0; j < hbkd_pkg::MAX_SLOTS; j++)
        begin
            if (!found && key != '0 && prior[j] == key)
            begin
                found       = 1'b1;
                res.held[j] = 1'b1;
            end
        end
        res.press = (key != '0) && !found;
    end

endmodule
`default_nettype wire

// ===== hdl/hbkd_merge.sv =====
`default_nettype none
// Combines the lane results and the modifier compare into one event mask.
module hbkd_merge (
    input  wire hbkd_pkg::lane_res_t [hbkd_pkg::MAX_SLOTS-1:0] lanes,
    input  wire logic [7:0]                                    new_mod,
    input  wire logic [7:0]                                    prior_mod,
    input  wire hbkd_pkg::slots_t                              prior,
    output logic [hbkd_pkg::EVT_CNT-1:0]                       mask
);

    logic [hbkd_pkg::MAX_SLOTS-1:0] held_any;

    always_comb
    begin
        held_any = '0;
        mask     = '0;
        for (int i = 0; i < hbkd_pkg::MAX_SLOTS; i++)
        begin
            held_any = held_any | lanes[i].held;
            mask[i]  = lanes[i].press;
        end
        for (int b = 0; b < hbkd_pkg::MOD_BITS; b++)
        begin
            mask[hbkd_pkg::MODP_BASE + b] = new_mod[b] && !prior_mod[b];
            mask[hbkd_pkg::MODR_BASE + b] = !new_mod[b] && prior_mod[b];
        end
        for (int i = 0; i < hbkd_pkg::MAX_SLOTS; i++)
        begin
            mask[hbkd_pkg::KEYR_BASE + i] = !held_any[i] && (prior[i] != '0);
        end
    end

endmodule
`default_nettype wire
